// File: src/s2rb_pkg.sv
// ----------------------------------------------------------------------------
// s2rb_pkg
// types, codes and sizing constants shared by the spi to register bus bridge
// ----------------------------------------------------------------------------
package s2rb_pkg;

  // framing sizes
  localparam int ADDR_BYTES     = 3;
  localparam int MAX_DATA_BYTES = 4;
  localparam int WORD_BYTES     = 4;
  localparam int ADDR_W         = 24;
  localparam int ADDR_CNT_W     = $clog2(ADDR_BYTES + 1);
  localparam int LEN_W          = $clog2(MAX_DATA_BYTES + 1);
  localparam int BIDX_W         = $clog2(MAX_DATA_BYTES + 1);
  localparam int HDR_LEN_W      = 7;

  // special bytes returned to the host
  localparam logic [7:0] IDLE_BYTE = 8'h01;
  localparam logic [7:0] ERR_BYTE  = 8'hFF;

  // item commands
  typedef enum logic [1:0] {
    CMD_XFER       = 2'd0,
    CMD_CS_START   = 2'd1,
    CMD_CS_RELEASE = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_t;

  // framing phase
  typedef enum logic [2:0] {
    PH_RELEASED = 3'd0,
    PH_START    = 3'd1,
    PH_ADDRESS  = 3'd2,
    PH_DATA_WR  = 3'd3,
    PH_DATA_RD  = 3'd4,
    PH_DONE     = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  tx_byte;
    logic [31:0] reg_read_data;
  } item_t;

  typedef struct packed {
    logic [7:0]        rx_byte;
    logic              framing_error;
    logic              read_strobe;
    logic              write_strobe;
    logic [ADDR_W-1:0] bus_address;
    logic [2:0]        bus_size;
    logic [31:0]       write_data;
  } result_t;

  typedef struct packed {
    phase_t                phase;
    logic                  is_read;
    logic [LEN_W-1:0]      length;
    logic [BIDX_W-1:0]     byte_index;
    logic [ADDR_CNT_W-1:0] address_count;
    logic [ADDR_W-1:0]     address_word;
    logic [31:0]           data_word;
  } frame_state_t;

  typedef struct packed {
    frame_state_t st;
    result_t      res;
  } xchg_t;

endpackage

// File: src/s2rb_if.sv
// ----------------------------------------------------------------------------
// s2rb_if
// valid/ready channels for spi words in and bridge results out
// ----------------------------------------------------------------------------
interface s2rb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  tx_byte;
  logic [31:0] reg_read_data;

  modport source (output valid, command, tx_byte, reg_read_data, input ready);
  modport sink   (input valid, command, tx_byte, reg_read_data, output ready);
endinterface

interface s2rb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic        framing_error;
  logic        read_strobe;
  logic        write_strobe;
  logic [23:0] bus_address;
  logic [2:0]  bus_size;
  logic [31:0] write_data;

  modport source (output valid, rx_byte, framing_error, read_strobe, write_strobe,
                  bus_address, bus_size, write_data, input ready);
  modport sink   (input valid, rx_byte, framing_error, read_strobe, write_strobe,
                  bus_address, bus_size, write_data, output ready);
endinterface

// File: src/s2rb_framer.sv
// ----------------------------------------------------------------------------
// s2rb_framer
// packet framing state and per-word result logic
// ----------------------------------------------------------------------------
module s2rb_framer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  s2rb_pkg::item_t   item,
  input  logic              preread_en,
  output s2rb_pkg::result_t res
);

  s2rb_pkg::frame_state_t st_r;
  s2rb_pkg::frame_state_t st_nxt;
  s2rb_pkg::xchg_t        first;
  s2rb_pkg::xchg_t        second;
  s2rb_pkg::result_t      zero_res;

  // one framing exchange on top of a partly filled result
  function automatic s2rb_pkg::xchg_t do_xchg(
    input s2rb_pkg::frame_state_t s_in,
    input s2rb_pkg::result_t      r_in,
    input logic [7:0]             tx,
    input logic [31:0]            rdata
  );
    s2rb_pkg::xchg_t                 x;
    logic [s2rb_pkg::HDR_LEN_W-1:0]  hdr_len;
    logic [s2rb_pkg::ADDR_CNT_W-1:0] cnt;
    logic [s2rb_pkg::BIDX_W-1:0]     bidx_inc;
    x.st            = s_in;
    x.res           = r_in;
    x.res.rx_byte   = s2rb_pkg::IDLE_BYTE;
    hdr_len         = {1'b0, tx[5:0]} + s2rb_pkg::HDR_LEN_W'(1);
    cnt             = s_in.address_count;
    bidx_inc        = s_in.byte_index + s2rb_pkg::BIDX_W'(1);
    case (s_in.phase)
      s2rb_pkg::PH_START: begin
        x.st.is_read = tx[7];
        if (hdr_len > s2rb_pkg::HDR_LEN_W'(s2rb_pkg::MAX_DATA_BYTES)) begin
          x.st.length = s2rb_pkg::LEN_W'(s2rb_pkg::MAX_DATA_BYTES);
        end else begin
          x.st.length = s2rb_pkg::LEN_W'(hdr_len);
        end
        x.st.byte_index    = '0;
        x.st.address_count = s2rb_pkg::ADDR_CNT_W'(s2rb_pkg::ADDR_BYTES);
        x.st.phase         = s2rb_pkg::PH_ADDRESS;
      end
      s2rb_pkg::PH_ADDRESS: begin
        if (cnt != '0) begin
          cnt = cnt - s2rb_pkg::ADDR_CNT_W'(1);
        end
        x.st.address_count = cnt;
        // only the low three byte positions exist in the address word
        if (cnt < s2rb_pkg::ADDR_CNT_W'(3)) begin
          x.st.address_word[{cnt[1:0], 3'b000} +: 8] = tx;
        end
        if (cnt == '0) begin
          if (!s_in.is_read) begin
            x.st.phase = s2rb_pkg::PH_DATA_WR;
          end else begin
            x.st.data_word      = rdata;
            x.res.read_strobe   = 1'b1;
            x.res.bus_address   = x.st.address_word;
            x.res.bus_size      = 3'(s_in.length);
            x.st.phase          = s2rb_pkg::PH_DATA_RD;
          end
        end
      end
      s2rb_pkg::PH_DATA_WR: begin
        if (s_in.byte_index < s2rb_pkg::BIDX_W'(s2rb_pkg::WORD_BYTES)) begin
          x.st.data_word[{s_in.byte_index[1:0], 3'b000} +: 8] = tx;
        end
        x.st.byte_index = bidx_inc;
        if (bidx_inc >= s2rb_pkg::BIDX_W'(s_in.length)) begin
          x.res.write_strobe = 1'b1;
          x.res.bus_address  = s_in.address_word;
          x.res.bus_size     = 3'(s_in.length);
          x.res.write_data   = x.st.data_word;
          x.st.phase         = s2rb_pkg::PH_START;
        end
      end
      s2rb_pkg::PH_DATA_RD: begin
        if (s_in.byte_index < s2rb_pkg::BIDX_W'(s2rb_pkg::WORD_BYTES)) begin
          x.res.rx_byte = s_in.data_word[{s_in.byte_index[1:0], 3'b000} +: 8];
        end else begin
          x.res.rx_byte = 8'h00;
        end
        x.st.byte_index = bidx_inc;
        if (bidx_inc >= s2rb_pkg::BIDX_W'(s_in.length)) begin
          x.st.phase = s2rb_pkg::PH_DONE;
        end
      end
      default: begin
        // word outside a packet
        x.st.phase          = s2rb_pkg::PH_START;
        x.res.framing_error = 1'b1;
        x.res.rx_byte       = s2rb_pkg::ERR_BYTE;
      end
    endcase
    return x;
  endfunction

  assign zero_res = '0;

  always_comb begin
    first  = do_xchg(st_r, zero_res, item.tx_byte, item.reg_read_data);
    second = first;
    // preread: the address-completing word already carries the first data byte
    if (preread_en && (st_r.phase != s2rb_pkg::PH_DATA_RD)
        && (first.st.phase == s2rb_pkg::PH_DATA_RD)) begin
      second = do_xchg(first.st, first.res, s2rb_pkg::ERR_BYTE, item.reg_read_data);
    end
  end

  always_comb begin
    st_nxt      = st_r;
    res         = zero_res;
    res.rx_byte = s2rb_pkg::IDLE_BYTE;
    unique case (s2rb_pkg::cmd_t'(item.command))
      s2rb_pkg::CMD_XFER: begin
        st_nxt = second.st;
        res    = second.res;
      end
      s2rb_pkg::CMD_CS_START: begin
        st_nxt.phase        = s2rb_pkg::PH_START;
        st_nxt.is_read      = 1'b0;
        st_nxt.address_word = '0;
        st_nxt.data_word    = '0;
      end
      s2rb_pkg::CMD_CS_RELEASE: begin
        st_nxt.phase = s2rb_pkg::PH_RELEASED;
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase         <= s2rb_pkg::PH_START;
      st_r.is_read       <= 1'b0;
      st_r.length        <= s2rb_pkg::LEN_W'(1);
      st_r.byte_index    <= '0;
      st_r.address_count <= s2rb_pkg::ADDR_CNT_W'(s2rb_pkg::ADDR_BYTES);
      st_r.address_word  <= '0;
      st_r.data_word     <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: src/spi_to_register_bus_bridge.sv
// ----------------------------------------------------------------------------
// spi_to_register_bus_bridge
// spi target framing that turns host words into register bus reads and writes
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake         payload
//   in_ch     in   valid / ready     command, tx_byte, reg_read_data
//   out_ch    out  valid / ready     rx_byte, framing_error, strobes, address,
//                                    size, write_data
//   cfg_      in   cfg_wr_en         cfg_wr_data -> preread enable
//
// two register stages: an input register and a result register, with the
// framing logic between them; one word per cycle while out_ch does not stall
// each word yields exactly one result word
// a stalled out_ch holds the result register and backs up into the input
// register; both stages refill in the cycle the sink takes a result
// synchronous active-low reset puts framing at the header phase with
// cleared address and data words and preread disabled
//
module spi_to_register_bus_bridge (
  input  logic        clk,
  input  logic        rst_n,
  s2rb_in_if.sink     in_ch,
  s2rb_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  // configuration
  logic preread_r;

  // input register
  s2rb_pkg::item_t inq_r;
  logic            inq_valid_r;
  logic            inq_valid_nxt;

  // result register
  s2rb_pkg::result_t res_r;
  s2rb_pkg::result_t frame_res;
  logic              out_valid_r;
  logic              out_valid_nxt;

  logic in_take;
  logic adv;

  // the queued word moves into the result register when it is free or draining
  assign adv     = inq_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !inq_valid_r || adv;
  assign in_take = in_ch.valid && in_ch.ready;

  always_comb begin
    inq_valid_nxt = inq_valid_r;
    if (in_take) begin
      inq_valid_nxt = 1'b1;
    end else if (adv) begin
      inq_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preread_r   <= 1'b0;
      inq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        preread_r <= cfg_wr_data;
      end
      inq_valid_r <= inq_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      inq_r.command       <= in_ch.command;
      inq_r.tx_byte       <= in_ch.tx_byte;
      inq_r.reg_read_data <= in_ch.reg_read_data;
    end
    if (adv) begin
      res_r <= frame_res;
    end
  end

  // framing state advances once per word leaving the input register
  s2rb_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (adv),
    .item       (inq_r),
    .preread_en (preread_r),
    .res        (frame_res)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.rx_byte       = res_r.rx_byte;
  assign out_ch.framing_error = res_r.framing_error;
  assign out_ch.read_strobe   = res_r.read_strobe;
  assign out_ch.write_strobe  = res_r.write_strobe;
  assign out_ch.bus_address   = res_r.bus_address;
  assign out_ch.bus_size      = res_r.bus_size;
  assign out_ch.write_data    = res_r.write_data;

endmodule

// File: tb/tb_spi_to_register_bus_bridge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_to_register_bus_bridge
// self-checking bench for the spi to register bus bridge: a queue-fed driver
// offers host words, a frame tracker predicts each result word, and a monitor
// compares every result field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_spi_to_register_bus_bridge;
  import s2rb_pkg::*;

  // how long the receiver holds off during the back-pressure phase
  localparam int HOLD_CYCLES = 400;
  // cycles with no handshake on either side before the run is declared hung
  localparam int STALL_LIMIT = 4000;
  // byte clocked in by the block itself for the preread exchange
  localparam logic [7:0] PREREAD_TX = 8'hFF;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  s2rb_in_if  in_ch ();
  s2rb_out_if out_ch ();

  spi_to_register_bus_bridge DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // stimulus and expectations
  item_t   pending_words[$];
  result_t expected_results[$];
  int      words_queued;
  int      mismatches = 0;

  // idle percentages for each side, changed only between phases
  int src_idle_pct;
  int snk_idle_pct;

  // receiver hold-off request, toggled by the sequencer
  logic hold_kick;
  logic hold_seen = 1'b0;
  int   sink_hold = 0;

  // frame tracker: the bench's own copy of the framing state, at reset values
  phase_t                fr_phase    = PH_START;
  logic                  fr_is_read  = 1'b0;
  logic [LEN_W-1:0]      fr_length   = LEN_W'(1);
  logic [BIDX_W-1:0]     fr_byte_idx = '0;
  logic [ADDR_CNT_W-1:0] fr_addr_cnt = ADDR_CNT_W'(ADDR_BYTES);
  logic [ADDR_W-1:0]     fr_addr     = '0;
  logic [31:0]           fr_data     = '0;
  logic                  preread_on;

  // one framing exchange; updates the tracker and the strobe, error and bus fields of res
  task automatic advance_frame(input logic [7:0] tx, input logic [31:0] rdata,
                               inout result_t res, output logic [7:0] rx);
    int unsigned hdr_len;
    rx = IDLE_BYTE;
    case (fr_phase)
      PH_START: begin
        // header: bit 7 read flag, bits 5..0 length minus one
        fr_is_read = tx[7];
        hdr_len = tx[5:0] + 1;
        if (hdr_len > MAX_DATA_BYTES) hdr_len = MAX_DATA_BYTES;
        fr_length = LEN_W'(hdr_len);
        fr_byte_idx = '0;
        fr_addr_cnt = ADDR_CNT_W'(ADDR_BYTES);
        fr_phase = PH_ADDRESS;
      end
      PH_ADDRESS: begin
        // address bytes arrive most significant first
        if (fr_addr_cnt > 0) fr_addr_cnt = fr_addr_cnt - 1'b1;
        if (fr_addr_cnt < ADDR_W / 8) fr_addr[fr_addr_cnt*8 +: 8] = tx;
        if (fr_addr_cnt == 0) begin
          if (!fr_is_read) begin
            fr_phase = PH_DATA_WR;
          end else begin
            // bus read goes out as soon as the address is complete
            fr_data = rdata;
            res.read_strobe = 1'b1;
            res.bus_address = fr_addr;
            res.bus_size = fr_length;
            fr_phase = PH_DATA_RD;
          end
        end
      end
      PH_DATA_WR: begin
        if (fr_byte_idx < WORD_BYTES) fr_data[fr_byte_idx*8 +: 8] = tx;
        fr_byte_idx = fr_byte_idx + 1'b1;
        if (fr_byte_idx >= fr_length) begin
          res.write_strobe = 1'b1;
          res.bus_address = fr_addr;
          res.bus_size = fr_length;
          res.write_data = fr_data;
          fr_phase = PH_START;
        end
      end
      PH_DATA_RD: begin
        rx = (fr_byte_idx < WORD_BYTES) ? fr_data[fr_byte_idx*8 +: 8] : 8'h00;
        fr_byte_idx = fr_byte_idx + 1'b1;
        if (fr_byte_idx >= fr_length) fr_phase = PH_DONE;
      end
      default: begin
        // word outside a packet: error byte and restart at the header
        fr_phase = PH_START;
        res.framing_error = 1'b1;
        rx = ERR_BYTE;
      end
    endcase
  endtask

  // expected result word for one accepted host word
  task automatic predict_word(input item_t w, output result_t res);
    phase_t     was;
    logic [7:0] rx;
    res = '0;
    rx = IDLE_BYTE;
    case (cmd_t'(w.command))
      CMD_XFER: begin
        was = fr_phase;
        advance_frame(w.tx_byte, w.reg_read_data, res, rx);
        // preread: the address-completing word already carries data byte 0
        if (preread_on && was != PH_DATA_RD && fr_phase == PH_DATA_RD)
          advance_frame(PREREAD_TX, w.reg_read_data, res, rx);
      end
      CMD_CS_START: begin
        fr_phase = PH_START;
        fr_is_read = 1'b0;
        fr_addr = '0;
        fr_data = '0;
      end
      CMD_CS_RELEASE: begin
        fr_phase = PH_RELEASED;
      end
      default: ;
    endcase
    res.rx_byte = rx;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued words, predicts each one at its handshake
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : word_driver
    item_t   next_word;
    result_t predicted;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_word(item_t'({in_ch.command, in_ch.tx_byte, in_ch.reg_read_data}),
                     predicted);
        expected_results.push_back(predicted);
      end
      // a held word stays put until it is taken
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_word = pending_words.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.command <= next_word.command;
          in_ch.tx_byte <= next_word.tx_byte;
          in_ch.reg_read_data <= next_word.reg_read_data;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks result words and drives the receiver's ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no expectation: rx_byte 0x%0h", out_ch.rx_byte);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("rx_byte", 32'(want.rx_byte), 32'(out_ch.rx_byte));
          check_field("framing_error", 32'(want.framing_error),
                      32'(out_ch.framing_error));
          check_field("read_strobe", 32'(want.read_strobe), 32'(out_ch.read_strobe));
          check_field("write_strobe", 32'(want.write_strobe), 32'(out_ch.write_strobe));
          check_field("bus_address", 32'(want.bus_address), 32'(out_ch.bus_address));
          check_field("bus_size", 32'(want.bus_size), 32'(out_ch.bus_size));
          check_field("write_data", want.write_data, out_ch.write_data);
        end
      end
      // a new hold request starts a long stretch with ready low
      if (hold_kick != hold_seen) begin
        hold_seen <= hold_kick;
        sink_hold <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (sink_hold > 0) begin
        sink_hold <= sink_hold - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: a run of cycles with no handshake at all means a hang
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $error("no handshake for %0d cycles", STALL_LIMIT);
    $display("** spi_to_register_bus_bridge: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_word(input cmd_t c, input logic [7:0] tx, input logic [31:0] rd);
    pending_words.push_back(item_t'({c, tx, rd}));
    words_queued++;
  endtask

  task automatic add_xfer(input logic [7:0] tx);
    add_word(CMD_XFER, tx, $urandom());
  endtask

  // header plus address; bit 6 of the header is don't-care, so randomize it
  task automatic add_header(input logic rd, input logic [5:0] len_code,
                            input logic [23:0] addr);
    add_xfer({rd, 1'($urandom_range(1)), len_code});
    add_xfer(addr[23:16]);
    add_xfer(addr[15:8]);
    add_xfer(addr[7:0]);
  endtask

  // let everything in flight come out before touching config or idling
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_preread(input logic v);
    wait_drained();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    preread_on = v;
  endtask

  // mostly well-formed packets with random content, plus broken ones and noise
  task automatic add_random_traffic(input int n_words);
    int       target;
    int       roll;
    int       n_data;
    int       cut;
    logic     rd;
    logic [5:0] len_code;
    target = words_queued + n_words;
    while (words_queued < target) begin
      roll = $urandom_range(99);
      rd = 1'($urandom_range(1));
      len_code = ($urandom_range(9) < 7) ? 6'($urandom_range(3)) : 6'($urandom_range(63));
      n_data = (len_code + 1 > MAX_DATA_BYTES) ? MAX_DATA_BYTES : len_code + 1;
      if (rd && preread_on) n_data--;
      if (roll < 75) begin
        if ($urandom_range(9) < 8) add_word(CMD_CS_START, 8'($urandom()), $urandom());
        add_header(rd, len_code, 24'($urandom()));
        repeat (n_data) add_xfer(8'($urandom()));
        // overrun past the end of the packet now and then
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) add_xfer(8'($urandom()));
        if ($urandom_range(1)) add_word(CMD_CS_RELEASE, 8'($urandom()), $urandom());
      end else if (roll < 88) begin
        // packet cut short by a chip select change
        add_word(CMD_CS_START, 8'($urandom()), $urandom());
        cut = $urandom_range(0, 5);
        add_xfer({rd, 1'($urandom_range(1)), len_code});
        repeat (cut) add_xfer(8'($urandom()));
        add_word($urandom_range(1) ? CMD_CS_START : CMD_CS_RELEASE, 8'($urandom()),
                 $urandom());
      end else begin
        add_word(cmd_t'($urandom_range(3)), 8'($urandom()), $urandom());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    hold_kick = 1'b0;
    words_queued = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    preread_on = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed, preread off
    set_preread(1'b0);
    add_word(CMD_CS_START, 8'h00, 32'h0);
    add_xfer(8'h43);                        // write, length 4
    add_xfer(8'hFF); add_xfer(8'hFF); add_xfer(8'hFF);
    add_xfer(8'h00); add_xfer(8'hFF); add_xfer(8'h5A); add_xfer(8'hA5);
    add_xfer(8'hBF);                        // read, length 64 clamps to 4
    add_xfer(8'h00); add_xfer(8'h00);
    add_word(CMD_XFER, 8'h00, 32'hFFFF_FFFF);
    repeat (4) add_xfer(8'h00);
    add_xfer(8'h00);                        // overrun after a finished read
    add_word(CMD_NOP, 8'hFF, 32'h0);
    add_word(CMD_CS_RELEASE, 8'h00, 32'h0);
    add_xfer(8'h12);                        // word while released
    add_xfer(8'h00);                        // one-byte write keeps stale upper bytes
    add_xfer(8'h12); add_xfer(8'h34); add_xfer(8'h56);
    add_xfer(8'h77);

    // directed, preread on
    set_preread(1'b1);
    add_word(CMD_CS_START, 8'h00, 32'h0);
    add_header(1'b1, 6'd0, 24'hABCDEF);     // one-byte read ends on the address word
    add_xfer(8'h00);
    add_header(1'b1, 6'd3, 24'h000001);     // read after error, no chip select

    // sender idles 20 percent of the time, receiver 61 percent
    set_preread(1'b1);
    src_idle_pct = 20;
    snk_idle_pct = 61;
    add_random_traffic(650);

    // and the other way round
    set_preread(1'b0);
    src_idle_pct = 61;
    snk_idle_pct = 20;
    add_random_traffic(650);

    // no idling; receiver holds off at the start so the block backs up
    set_preread(1'b1);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_kick = ~hold_kick;
    add_random_traffic(650);

    wait_drained();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected result words never arrived", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("** spi_to_register_bus_bridge: PASSED **");
    else
      $display("** spi_to_register_bus_bridge: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
src/s2rb_pkg.sv
src/s2rb_if.sv
src/s2rb_framer.sv
src/spi_to_register_bus_bridge.sv
tb/tb_spi_to_register_bus_bridge.sv
